// ===== sv/assert_macros.svh =====
// Assertion macros shared by the checksum frame checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, suppressed while reset is asserted (active low).
`define CKFC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define CKFC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/ckfc_pkg.sv =====
// Types and constants for the checksum frame checker.
`timescale 1ns / 1ps

package ckfc_pkg;

    localparam int SUM_W  = 20;
    localparam int SENT_W = 30;
    localparam int STAT_W = 3;
    localparam int DLEN_W = 4;

    localparam logic [7:0] CH_OPEN  = 8'h28; // '('
    localparam logic [7:0] CH_CLOSE = 8'h29; // ')'
    localparam logic [7:0] CH_END   = 8'h2A; // '*'
    localparam logic [7:0] CH_ZERO  = 8'h30; // '0'
    localparam logic [7:0] CH_NINE  = 8'h39; // '9'

    localparam logic [SUM_W-1:0]  SUM_LIMIT = {SUM_W{1'b1}};
    localparam logic [DLEN_W-1:0] DLEN_MAX  = {DLEN_W{1'b1}};

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_MISMATCH = 3'd1;
    localparam logic [STAT_W-1:0] ST_COUNT    = 3'd2;
    localparam logic [STAT_W-1:0] ST_BAD      = 3'd3;
    localparam logic [STAT_W-1:0] ST_LONG     = 3'd4;

    typedef enum logic [3:0] {
        PH_SKIP = 4'b0001,
        PH_SUM  = 4'b0010,
        PH_LEN  = 4'b0100,
        PH_CHK  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [SUM_W-1:0]  computed_sum;
        logic [SENT_W-1:0] sent_sum;
        logic [STAT_W-1:0] status;
    } t_result;

endpackage

// ===== sv/ckfc_parser.sv =====
// Per-frame parse state and end-of-frame status evaluation.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ckfc_parser #(
    parameter int MAX_FRAME  = 4096,
    parameter int MAX_DIGITS = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [7:0]        i_byte,
    output logic              o_is_end,
    output ckfc_pkg::t_result o_result
);
    import ckfc_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME);
    localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(MAX_FRAME - 1);
    localparam logic [DLEN_W-1:0] MAXD     = DLEN_W'(MAX_DIGITS);

    t_phase              r_phase,  n_phase;
    logic [CNT_W-1:0]    r_count,  n_count;
    logic [SUM_W-1:0]    r_sum,    n_sum;
    logic [DLEN_W-1:0]   r_dlen,   n_dlen;
    logic [SENT_W-1:0]   r_parsed, n_parsed;
    logic [DLEN_W-1:0]   r_seen,   n_seen;
    logic [STAT_W-1:0]   r_err,    n_err;

    logic                is_digit;
    logic [7:0]          diff;
    logic [3:0]          dval;
    logic [SUM_W:0]      sum_ext;
    logic [DLEN_W:0]     dlen_ext;
    logic [SENT_W+3:0]   parsed_ext;
    logic [STAT_W-1:0]   chk;
    logic [STAT_W-1:0]   err_long;

    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign diff     = i_byte - CH_ZERO;
    assign dval     = diff[3:0];
    assign sum_ext  = {1'b0, r_sum} + {{(SUM_W-7){1'b0}}, i_byte};
    assign dlen_ext = {1'b0, r_dlen} + {1'b0, dval};
    // value * 10 + digit as shift-add
    assign parsed_ext = {1'b0, r_parsed, 3'b000} + {3'b000, r_parsed, 1'b0}
                      + {{SENT_W{1'b0}}, dval};
    assign o_is_end = (i_byte == CH_END);

    // status at '*': highest of the sticky error and the final checks
    always_comb begin
        if (r_phase != PH_CHK) begin
            chk = ST_BAD;
        end else if ((r_dlen > MAXD) || (r_seen < r_dlen)) begin
            chk = ST_COUNT;
        end else if (r_parsed != {{(SENT_W-SUM_W){1'b0}}, r_sum}) begin
            chk = ST_MISMATCH;
        end else begin
            chk = ST_OK;
        end
        o_result.status       = (chk > r_err) ? chk : r_err;
        o_result.sent_sum     = r_parsed;
        o_result.computed_sum = r_sum;
    end

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_sum    = r_sum;
        n_dlen   = r_dlen;
        n_parsed = r_parsed;
        n_seen   = r_seen;
        err_long = r_err;
        if (r_count >= CNT_LAST) begin
            err_long = (ST_LONG > r_err) ? ST_LONG : r_err;
        end else begin
            n_count = r_count + 1'b1;
        end
        n_err = err_long;
        case (r_phase)
            PH_SKIP: begin
                n_phase = PH_SUM;
            end
            PH_SUM: begin
                // the byte right after the skipped one is always summed
                if ((i_byte == CH_OPEN) && (r_count != CNT_W'(1))) begin
                    n_phase = PH_LEN;
                end else if (sum_ext > {1'b0, SUM_LIMIT}) begin
                    n_sum = SUM_LIMIT;
                end else begin
                    n_sum = sum_ext[SUM_W-1:0];
                end
            end
            PH_LEN: begin
                if (i_byte == CH_CLOSE) begin
                    n_phase = PH_CHK;
                end else if (is_digit) begin
                    n_dlen = dlen_ext[DLEN_W] ? DLEN_MAX : dlen_ext[DLEN_W-1:0];
                end else begin
                    n_err = (ST_BAD > err_long) ? ST_BAD : err_long;
                end
            end
            PH_CHK: begin
                if ((r_seen < r_dlen) && (r_seen < MAXD)) begin
                    if (is_digit) begin
                        n_parsed = parsed_ext[SENT_W-1:0];
                    end else begin
                        n_err = (ST_BAD > err_long) ? ST_BAD : err_long;
                    end
                end
                if (r_seen < DLEN_MAX) begin
                    n_seen = r_seen + 1'b1;
                end
            end
            default: begin
                n_phase = PH_SKIP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SKIP;
            r_count  <= '0;
            r_sum    <= '0;
            r_dlen   <= '0;
            r_parsed <= '0;
            r_seen   <= '0;
            r_err    <= ST_OK;
        end else if (i_fire) begin
            if (o_is_end) begin
                r_phase  <= PH_SKIP;
                r_count  <= '0;
                r_sum    <= '0;
                r_dlen   <= '0;
                r_parsed <= '0;
                r_seen   <= '0;
                r_err    <= ST_OK;
            end else begin
                r_phase  <= n_phase;
                r_count  <= n_count;
                r_sum    <= n_sum;
                r_dlen   <= n_dlen;
                r_parsed <= n_parsed;
                r_seen   <= n_seen;
                r_err    <= n_err;
            end
        end
    end

    `CKFC_ASSERT(a_rearm, i_clk, i_rst_n,
        $past(i_fire && o_is_end) |-> (r_phase == PH_SKIP && r_count == '0),
        "parser did not rearm after end of frame")
    `CKFC_ASSERT(a_count_cap, i_clk, i_rst_n,
        r_count <= CNT_LAST, "byte count beyond frame limit")
    `CKFC_ASSERT(a_phase_onehot, i_clk, i_rst_n,
        $onehot(r_phase), "phase register not one-hot")

endmodule

// ===== sv/checksum_frame_checker_core.sv =====
// Top level of the checksum frame checker: input stage, parser, result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Checks frames of the form  X payload ( len ) digits *  one byte per word.
// Slave channel (i_s_*): one received byte per word in tdata[7:0].
// Master channel (o_m_*): one result word per '*' byte; tdata carries
// status, the checksum parsed from the frame and the computed payload sum.
// All other bytes update the frame state and produce no output word.
//
// Throughput: one byte per cycle, sustained while no '*' waits on a full result
// register. The byte is registered on accept, then parsed by the frame state
// update, which is one add/saturate, one compare and a shift-add multiply by ten.
// The result word of a parsed '*' is captured in the result register that drives o_m_*.
//
// Stall: the result register holds its word until i_m_tready. While it is
// full, a '*' waiting in the input stage is held, and o_s_tready drops until
// it moves on; other bytes keep flowing since they need no output slot.
//
// Reset (synchronous, active low): both stages empty, the frame state
// returns to "skip first byte" with all sums, counts and errors cleared.
module checksum_frame_checker_core #(
    parameter int MAX_FRAME  = 4096,
    parameter int MAX_DIGITS = 9
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata    // [2:0] status, [32:3] sent_sum,
                                     // [52:33] computed_sum, [55:53] zero
);
    import ckfc_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out_data;

    logic       is_end;
    logic       out_free;
    logic       fire;
    t_result    result;

    // parse stage moves when a byte is present; '*' also needs the output slot
    assign out_free   = !r_out_valid || i_m_tready;
    assign fire       = r_in_valid && (!is_end || out_free);
    assign o_s_tready = !r_in_valid || fire;

    ckfc_parser #(
        .MAX_FRAME  (MAX_FRAME),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_byte   (r_in_byte),
        .o_is_end (is_end),
        .o_result (result)
    );

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && is_end) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && is_end) begin
            r_out_data <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_data};

    `CKFC_ASSERT_ALWAYS(a_rst_empty, i_clk,
        !i_rst_n |=> (!r_out_valid && !r_in_valid), "stages not empty after reset")
    `CKFC_ASSERT(a_out_from_end, i_clk, i_rst_n,
        $rose(r_out_valid) |-> $past(fire && is_end), "result word without end byte")
    `CKFC_ASSERT(a_status_range, i_clk, i_rst_n,
        r_out_valid |-> (r_out_data.status <= ST_LONG), "status code out of range")

endmodule

// ===== verif/tb_checksum_frame_checker_core.sv =====
// Self-checking testbench for the checksum frame checker core.
`timescale 1ns / 1ps

module tb_checksum_frame_checker_core;
    import ckfc_pkg::*;

    localparam int MAX_FRAME    = 4096;
    localparam int MAX_DIGITS   = 9;
    localparam int RAND_BYTES   = 1600;      // size of the random part, in words
    localparam int HOLD_CYCLES  = 400;       // long receiver hold-off
    localparam int LIMIT_CYCLES = 800000;    // watchdog limit on the whole run

    // Frame shapes the random part draws from.
    typedef enum int {
        FR_GOOD,
        FR_WRONG_SUM,
        FR_SHORT,
        FR_EXTRA,
        FR_BAD_DIGIT,
        FR_BAD_LEN,
        FR_OVER_LEN,
        FR_SAT_LEN,
        FR_EARLY_END
    } t_frame_kind;

    // Expected-result store plus a bit-level copy of the frame parser.
    class frame_scoreboard;
        t_phase            ph;
        bit [12:0]         byte_cnt;
        bit [20:0]         run_sum;
        bit [DLEN_W-1:0]   dlen;
        bit [SENT_W-1:0]   parsed;
        bit [3:0]          seen;
        bit [STAT_W-1:0]   err;
        t_result           result_q[$];
        int                errors;

        function new();
            errors = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            ph       = PH_SKIP;
            byte_cnt = '0;
            run_sum  = '0;
            dlen     = '0;
            parsed   = '0;
            seen     = '0;
            err      = ST_OK;
        endfunction

        function void raise_err(bit [STAT_W-1:0] code);
            if (code > err) err = code;
        endfunction

        // Apply one accepted byte; a '*' queues the result it causes.
        function void note_byte(bit [7:0] c);
            bit              is_dig;
            bit [3:0]        d;
            bit [12:0]       pos;
            bit [STAT_W-1:0] chk;
            int unsigned     acc;
            t_result         r;
            pos    = byte_cnt;
            is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
            d      = 4'(c - CH_ZERO);
            if (c == CH_END) begin
                chk = ST_OK;
                if (ph != PH_CHK)
                    chk = ST_BAD;
                else if (dlen > MAX_DIGITS || seen < dlen)
                    chk = ST_COUNT;
                else if (32'(parsed) != 32'(run_sum))
                    chk = ST_MISMATCH;
                r.status       = (chk > err) ? chk : err;
                r.sent_sum     = parsed;
                r.computed_sum = run_sum[SUM_W-1:0];
                result_q.push_back(r);
                clear_frame();
                return;
            end
            if (byte_cnt >= 13'(MAX_FRAME - 1))
                raise_err(ST_LONG);   // byte count pins, byte still parsed
            else
                byte_cnt++;
            case (ph)
                PH_SKIP: ph = PH_SUM;
                PH_SUM: begin
                    // '(' right after the skipped byte is payload
                    if (c == CH_OPEN && pos != 13'd1) begin
                        ph = PH_LEN;
                    end else begin
                        acc = 32'(run_sum) + 32'(c);
                        if (acc > 32'(SUM_LIMIT)) acc = 32'(SUM_LIMIT);
                        run_sum = 21'(acc);
                    end
                end
                PH_LEN: begin
                    if (c == CH_CLOSE) begin
                        ph = PH_CHK;
                    end else if (is_dig) begin
                        acc = 32'(dlen) + 32'(d);
                        if (acc > 32'(DLEN_MAX)) acc = 32'(DLEN_MAX);
                        dlen = DLEN_W'(acc);
                    end else begin
                        raise_err(ST_BAD);
                    end
                end
                default: begin
                    if (seen < dlen && seen < MAX_DIGITS) begin
                        if (is_dig) parsed = SENT_W'(32'(parsed) * 10 + 32'(d));
                        else        raise_err(ST_BAD);
                    end
                    if (seen < 4'd15) seen++;
                end
            endcase
        endfunction

        function void cmp_field(string name, longint unsigned exp_v, logic [31:0] act_v);
            if (act_v !== 32'(exp_v)) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic [55:0] word);
            t_result e;
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result word: expected none, actual %h", $time, word);
                errors++;
                return;
            end
            e = result_q.pop_front();
            cmp_field("status",       e.status,       32'(word[2:0]));
            cmp_field("sent_sum",     e.sent_sum,     32'(word[32:3]));
            cmp_field("computed_sum", e.computed_sum, 32'(word[52:33]));
            cmp_field("pad",          0,              32'(word[55:53]));
        endfunction

        function int pending();
            return result_q.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = 8'h00;   // [7:0] rx_byte
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [55:0] o_m_tdata;           // [2:0] status, [32:3] sent_sum,
                                      // [52:33] computed_sum, [55:53] zero

    frame_scoreboard sb;
    bit [7:0]        frame_q[$];
    bit              hold_req = 1'b0;   // asks the receiver for one long hold-off
    bit              rush = 1'b0;       // sender offers back to back
    int              s_quiet = 0;
    int              r_quiet = 0;
    int              cycles = 0;

    checksum_frame_checker_core #(
        .MAX_FRAME  (MAX_FRAME),
        .MAX_DIGITS (MAX_DIGITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Every accepted result word goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
    end

    // Per-word wait drawn at random, with occasional runs of no waiting at all.
    function automatic int draw_gap(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            quiet = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    // Receiver: random stalls per word, one long hold-off on request.
    initial begin
        int n;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    i_m_tready <= 1'b0;
                end
            end else begin
                n = draw_gap(r_quiet);
                repeat (n) begin
                    @(negedge i_clk);
                    i_m_tready <= 1'b0;
                end
            end
            @(negedge i_clk);
            i_m_tready <= 1'b1;
            // ready is high here, so valid alone means a word was taken
            do @(posedge i_clk); while (!o_m_tvalid && !hold_req);
        end
    end

    task automatic send_byte(bit [7:0] b);
        int gap;
        gap = rush ? 0 : draw_gap(s_quiet);
        repeat (gap) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_byte(b);
    endtask

    task automatic send_str(string s);
        foreach (s[i]) send_byte(s[i]);
    endtask

    task automatic send_frame();
        foreach (frame_q[i]) send_byte(frame_q[i]);
    endtask

    // Sender goes idle, then waits for every expected result.
    task automatic wait_drained();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic int dec_digits(int unsigned v);
        int n;
        n = 1;
        while (v >= 10) begin
            v = v / 10;
            n++;
        end
        return n;
    endfunction

    // Random byte that is neither a digit nor one of the frame delimiters.
    function automatic bit [7:0] rand_plain();
        bit [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_OPEN || b == CH_CLOSE || b == CH_END);
        return b;
    endfunction

    // Build  X payload ( len ) digits *  in frame_q, optionally damaged.
    // forced_len > 0 fixes the checksum length, else it is drawn.
    task automatic build_frame(int npay, bit all_ones, int forced_len, t_frame_kind kind);
        bit [7:0]    b;
        bit [7:0]    digs[$];
        int unsigned sum;
        int unsigned v;
        int          len;
        int          rem;
        int          d;
        int          k;
        int          len_start;
        int          close_idx;
        frame_q.delete();
        do b = 8'($urandom_range(0, 255)); while (b == CH_END);
        frame_q.push_back(b);
        sum = 0;
        for (int i = 0; i < npay; i++) begin
            if (all_ones)
                b = 8'hFF;
            else if (i == 0 && $urandom_range(0, 3) == 0)
                b = CH_OPEN;          // summed: it sits at position one
            else
                do b = 8'($urandom_range(0, 255)); while (b == CH_OPEN || b == CH_END);
            frame_q.push_back(b);
            sum += b;
        end
        len = (forced_len > 0) ? forced_len : $urandom_range(dec_digits(sum), MAX_DIGITS);
        if (kind == FR_OVER_LEN) len = $urandom_range(MAX_DIGITS + 1, 15);
        if (kind == FR_SAT_LEN)  len = $urandom_range(16, 27);
        frame_q.push_back(CH_OPEN);
        len_start = frame_q.size();
        rem = len;
        while (rem > 0) begin
            if ($urandom_range(0, 5) == 0) frame_q.push_back(CH_ZERO);
            d = $urandom_range(1, (rem > 9) ? 9 : rem);
            frame_q.push_back(8'(CH_ZERO + d));
            rem -= d;
        end
        if (kind == FR_BAD_LEN)
            frame_q.insert($urandom_range(len_start, frame_q.size()), rand_plain());
        close_idx = frame_q.size();
        frame_q.push_back(CH_CLOSE);
        if (len > MAX_DIGITS) begin
            // count error anyway, content does not matter
            repeat ($urandom_range(0, 16)) frame_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        end else begin
            v = sum;
            for (int i = 0; i < len; i++) begin
                digs.push_front(8'(CH_ZERO + v % 10));
                v = v / 10;
            end
            k = $urandom_range(0, len - 1);
            if (kind == FR_WRONG_SUM)
                digs[k] = 8'(CH_ZERO + ((digs[k] - CH_ZERO) + $urandom_range(1, 9)) % 10);
            if (kind == FR_BAD_DIGIT)
                digs[k] = rand_plain();
            if (kind == FR_SHORT)
                while (digs.size() > k) void'(digs.pop_back());
            foreach (digs[i]) frame_q.push_back(digs[i]);
            if (kind == FR_EXTRA) begin
                repeat ($urandom_range(1, 5)) begin
                    do b = 8'($urandom_range(0, 255)); while (b == CH_END);
                    frame_q.push_back(b);
                end
            end
        end
        // cut anywhere before ')' so the '*' lands early
        if (kind == FR_EARLY_END) begin
            k = $urandom_range(0, close_idx);
            while (frame_q.size() > k) void'(frame_q.pop_back());
        end
        frame_q.push_back(CH_END);
    endtask

    initial begin
        int          rand_sent;
        int          r;
        t_frame_kind kind;
        sb = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames.
        send_str("*");                    // '*' as the very first byte
        send_str("A*");                   // '*' at position one
        send_str("X((2)40*");             // '(' at position one is payload
        send_str("Xa(1x)5*");             // bad length byte and sum mismatch together
        send_str("Xa(3)97*");             // short checksum
        send_str("Xa(2)97zz*");           // bytes past the length are ignored
        send_str("Xa(2)9z*");             // non-digit in the checksum
        send_str("Xa(55)0000000097*");    // length above the digit limit
        send_byte(8'h00);                 // extreme byte values, sum 255
        send_byte(8'hFF);
        send_byte(8'h00);
        send_str("(3)255*");
        wait_drained();

        // Frame at exactly the size limit (single length digit), then one
        // past it that also saturates the payload sum.
        do build_frame(MAX_FRAME - 12, 1'b0, 7, FR_GOOD);
        while (frame_q.size() != MAX_FRAME);
        send_frame();
        build_frame(4200, 1'b1, 7, FR_GOOD);
        send_frame();
        wait_drained();

        // Receiver holds off while the sender keeps offering: the output
        // slot and input stage fill, and the input stalls.
        hold_req = 1'b1;
        rush     = 1'b1;
        repeat (6) begin
            build_frame($urandom_range(1, 6), 1'b0, 0, FR_GOOD);
            send_frame();
        end
        rush = 1'b0;
        wait_drained();

        // Random part: mostly well-formed frames, some damaged, some noise.
        rand_sent = 0;
        while (rand_sent < RAND_BYTES) begin
            r = $urandom_range(0, 99);
            if (r < 85) begin
                kind = (r < 55) ? FR_GOOD : t_frame_kind'($urandom_range(FR_WRONG_SUM, FR_EARLY_END));
                build_frame($urandom_range(1, 12), 1'b0, 0, kind);
            end else begin
                frame_q.delete();
                repeat ($urandom_range(1, 20)) frame_q.push_back(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1)) frame_q.push_back(CH_END);
            end
            send_frame();
            rand_sent += frame_q.size();
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (sb.pending() != 0)
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/ckfc_pkg.sv
sv/ckfc_parser.sv
sv/checksum_frame_checker_core.sv
verif/tb_checksum_frame_checker_core.sv
